>>> rtl/sm83alu_pkg.sv
// shared types, command codes and flag positions of the sm83 alu and bit unit
package sm83alu_pkg;

    localparam int CMD_W = 5;

    localparam logic [CMD_W-1:0] CMD_ADD8   = 5'd0;
    localparam logic [CMD_W-1:0] CMD_ADC    = 5'd1;
    localparam logic [CMD_W-1:0] CMD_SUB    = 5'd2;
    localparam logic [CMD_W-1:0] CMD_SBC    = 5'd3;
    localparam logic [CMD_W-1:0] CMD_AND    = 5'd4;
    localparam logic [CMD_W-1:0] CMD_XOR    = 5'd5;
    localparam logic [CMD_W-1:0] CMD_OR     = 5'd6;
    localparam logic [CMD_W-1:0] CMD_CP     = 5'd7;
    localparam logic [CMD_W-1:0] CMD_INC8   = 5'd8;
    localparam logic [CMD_W-1:0] CMD_DEC8   = 5'd9;
    localparam logic [CMD_W-1:0] CMD_ADD16  = 5'd10;
    localparam logic [CMD_W-1:0] CMD_ADD_SP = 5'd11;
    localparam logic [CMD_W-1:0] CMD_RLC    = 5'd12;
    localparam logic [CMD_W-1:0] CMD_RRC    = 5'd13;
    localparam logic [CMD_W-1:0] CMD_RL     = 5'd14;
    localparam logic [CMD_W-1:0] CMD_RR     = 5'd15;
    localparam logic [CMD_W-1:0] CMD_SLA    = 5'd16;
    localparam logic [CMD_W-1:0] CMD_SRA    = 5'd17;
    localparam logic [CMD_W-1:0] CMD_SWAP   = 5'd18;
    localparam logic [CMD_W-1:0] CMD_SRL    = 5'd19;
    localparam logic [CMD_W-1:0] CMD_BIT    = 5'd20;
    localparam logic [CMD_W-1:0] CMD_RES    = 5'd21;
    localparam logic [CMD_W-1:0] CMD_SET    = 5'd22;

    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic [15:0]      a;
        logic [15:0]      b;
        logic [2:0]       bit_index;
        logic [3:0]       flags;
    } alu_req_t;

    typedef struct packed {
        logic [15:0] result;
        logic [3:0]  flags;
        logic        write_back;
    } alu_res_t;

    function automatic logic is_zero8(input logic [7:0] v);
        return v == 8'h00;
    endfunction

endpackage

>>> rtl/sm83alu_arith.sv
// arithmetic and logic group: 8-bit alu ops, inc/dec, 16-bit add, sp offset add
module sm83alu_arith (
    input  sm83alu_pkg::alu_req_t req,
    output sm83alu_pkg::alu_res_t res
);
    import sm83alu_pkg::*;

    logic [7:0]  a8;
    logic [7:0]  b8;
    logic        cin;
    logic        cin_use;
    logic [8:0]  sum9;
    logic [4:0]  hsum5;
    logic [8:0]  diff9;
    logic [4:0]  hdiff5;
    logic [7:0]  inc8;
    logic [7:0]  dec8;
    logic [16:0] sum17;
    logic [12:0] sum13;
    logic [15:0] sp_sum;
    logic [7:0]  r8;

    always_comb
    begin
        a8      = req.a[7:0];
        b8      = req.b[7:0];
        cin     = req.flags[FLAG_C];
        cin_use = cin & ((req.command == CMD_ADC) | (req.command == CMD_SBC));
        // carry-in is zero for the sp offset add, so these sums serve it too
        sum9    = {1'b0, a8} + {1'b0, b8} + {8'd0, cin_use};
        hsum5   = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, cin_use};
        diff9   = {1'b0, a8} - {1'b0, b8} - {8'd0, cin_use};
        hdiff5  = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, cin_use};
        inc8    = a8 + 8'd1;
        dec8    = a8 - 8'd1;
        sum17   = {1'b0, req.a} + {1'b0, req.b};
        sum13   = {1'b0, req.a[11:0]} + {1'b0, req.b[11:0]};
        sp_sum  = req.a + {{8{b8[7]}}, b8};
        r8      = 8'h00;

        res.result     = 16'h0000;
        res.flags      = req.flags;
        res.write_back = 1'b0;

        unique case (req.command)
            CMD_ADD8, CMD_ADC:
            begin
                r8             = sum9[7:0];
                res.result     = {8'h00, r8};
                res.flags      = {is_zero8(r8), 1'b0, hsum5[4], sum9[8]};
                res.write_back = 1'b1;
            end
            CMD_SUB, CMD_SBC:
            begin
                r8             = diff9[7:0];
                res.result     = {8'h00, r8};
                res.flags      = {is_zero8(r8), 1'b1, hdiff5[4], diff9[8]};
                res.write_back = 1'b1;
            end
            CMD_CP:
            begin
                res.flags = {is_zero8(diff9[7:0]), 1'b1, hdiff5[4], diff9[8]};
            end
            CMD_AND:
            begin
                r8             = a8 & b8;
                res.result     = {8'h00, r8};
                res.flags      = {is_zero8(r8), 1'b0, 1'b1, 1'b0};
                res.write_back = 1'b1;
            end
            CMD_XOR:
            begin
                r8             = a8 ^ b8;
                res.result     = {8'h00, r8};
                res.flags      = {is_zero8(r8), 3'b000};
                res.write_back = 1'b1;
            end
            CMD_OR:
            begin
                r8             = a8 | b8;
                res.result     = {8'h00, r8};
                res.flags      = {is_zero8(r8), 3'b000};
                res.write_back = 1'b1;
            end
            CMD_INC8:
            begin
                res.result     = {8'h00, inc8};
                res.flags      = {is_zero8(inc8), 1'b0, inc8[3:0] == 4'h0, cin};
                res.write_back = 1'b1;
            end
            CMD_DEC8:
            begin
                res.result     = {8'h00, dec8};
                res.flags      = {is_zero8(dec8), 1'b1, dec8[3:0] == 4'hF, cin};
                res.write_back = 1'b1;
            end
            CMD_ADD16:
            begin
                res.result     = sum17[15:0];
                res.flags      = {req.flags[FLAG_Z], 1'b0, sum13[12], sum17[16]};
                res.write_back = 1'b1;
            end
            CMD_ADD_SP:
            begin
                res.result     = sp_sum;
                res.flags      = {2'b00, hsum5[4], sum9[8]};
                res.write_back = 1'b1;
            end
            default:
            begin
                res.result     = 16'h0000;
                res.flags      = req.flags;
                res.write_back = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/sm83alu_cb.sv
// cb-prefix group: rotates, shifts, swap, and bit/res/set
module sm83alu_cb (
    input  sm83alu_pkg::alu_req_t req,
    output sm83alu_pkg::alu_res_t res
);
    import sm83alu_pkg::*;

    logic [7:0] a8;
    logic       cin;
    logic [7:0] r8;
    logic       cout;
    logic [7:0] mask;

    always_comb
    begin
        a8   = req.a[7:0];
        cin  = req.flags[FLAG_C];
        mask = 8'h01 << req.bit_index;
        r8   = 8'h00;
        cout = 1'b0;

        res.result     = 16'h0000;
        res.flags      = req.flags;
        res.write_back = 1'b0;

        unique case (req.command)
            CMD_RLC:  begin r8 = {a8[6:0], a8[7]}; cout = a8[7]; end
            CMD_RRC:  begin r8 = {a8[0], a8[7:1]}; cout = a8[0]; end
            CMD_RL:   begin r8 = {a8[6:0], cin};   cout = a8[7]; end
            CMD_RR:   begin r8 = {cin, a8[7:1]};   cout = a8[0]; end
            CMD_SLA:  begin r8 = {a8[6:0], 1'b0};  cout = a8[7]; end
            CMD_SRA:  begin r8 = {a8[7], a8[7:1]}; cout = a8[0]; end
            CMD_SWAP: begin r8 = {a8[3:0], a8[7:4]}; cout = 1'b0; end
            CMD_SRL:  begin r8 = {1'b0, a8[7:1]};  cout = a8[0]; end
            CMD_RES:  r8 = a8 & ~mask;
            CMD_SET:  r8 = a8 | mask;
            default:  r8 = 8'h00;
        endcase

        priority if (req.command == CMD_BIT)
        begin
            res.flags = {~a8[req.bit_index], 1'b0, 1'b1, cin};
        end
        else if (req.command == CMD_RES || req.command == CMD_SET)
        begin
            res.result     = {8'h00, r8};
            res.write_back = 1'b1;
        end
        else if (req.command >= CMD_RLC && req.command <= CMD_SRL)
        begin
            res.result     = {8'h00, r8};
            res.flags      = {is_zero8(r8), 1'b0, 1'b0, cout};
            res.write_back = 1'b1;
        end
        else
        begin
            res.result     = 16'h0000;
            res.flags      = req.flags;
            res.write_back = 1'b0;
        end
    end

endmodule

>>> rtl/sm83_alu_and_bit_unit_top.sv
// top level of the sm83 alu and bit unit: input register, alu groups, result register
//
//  channel | signals                                                               | dir
//  --------+-----------------------------------------------------------------------+-----
//  in      | in_valid in_ready command operand_a operand_b bit_index flags_in      | in
//  out     | out_valid out_ready result flags_out write_back                       | out
//
// one item per cycle sustained while out_ready is high; each item passes the input register, then the result register
// the alu itself is one combinational pass between those two registers
// reset clears both valid bits; payload registers are not reset
// a stall at out_ready holds the result register; the input register keeps
// taking an item while the result register drains, in_ready drops only when both are full
module sm83_alu_and_bit_unit_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [4:0]  command,
    input  logic [15:0] operand_a,
    input  logic [15:0] operand_b,
    input  logic [2:0]  bit_index,
    input  logic [3:0]  flags_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] result,
    output logic [3:0]  flags_out,
    output logic        write_back
);
    import sm83alu_pkg::*;

    alu_req_t req_reg;
    alu_req_t req_next;
    logic     s1_valid_reg;
    logic     s1_valid_next;
    alu_res_t res_reg;
    alu_res_t res_next;
    logic     out_valid_reg;
    logic     out_valid_next;

    alu_res_t arith_res;
    alu_res_t cb_res;
    logic     s1_adv;
    logic     in_fire;

    sm83alu_arith u_arith (
        .req (req_reg),
        .res (arith_res)
    );

    sm83alu_cb u_cb (
        .req (req_reg),
        .res (cb_res)
    );

    assign s1_adv   = s1_valid_reg & (~out_valid_reg | out_ready);
    assign in_ready = ~s1_valid_reg | s1_adv;
    assign in_fire  = in_valid & in_ready;

    always_comb
    begin
        req_next.command   = command;
        req_next.a         = operand_a;
        req_next.b         = operand_b;
        req_next.bit_index = bit_index;
        req_next.flags     = flags_in;

        s1_valid_next  = in_fire | (s1_valid_reg & ~s1_adv);
        out_valid_next = s1_adv | (out_valid_reg & ~out_ready);

        // unused codes fall through to a no-op with flags passed on
        priority if (req_reg.command <= CMD_ADD_SP)
        begin
            res_next = arith_res;
        end
        else if (req_reg.command <= CMD_SET)
        begin
            res_next = cb_res;
        end
        else
        begin
            res_next.result     = 16'h0000;
            res_next.flags      = req_reg.flags;
            res_next.write_back = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg <= req_next;
        end
        if (s1_adv)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign result     = res_reg.result;
    assign flags_out  = res_reg.flags;
    assign write_back = res_reg.write_back;

    // a result that is not written back always reads as zero
    a_nowb_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_back |-> result == 16'h0000)
        else $error("result not zero without write-back");

    // an item leaving the input register lands in the result register
    a_adv_fills: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid)
        else $error("advanced item missing from result register");

    // a held input register keeps its item while the output is blocked
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(req_reg))
        else $error("stalled item lost in input register");

    // the input side is never blocked while the input register is empty
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("input blocked with empty input register");

endmodule
